// ===== rtl/ipp_pkg.sv =====
`timescale 1ns / 1ps

package ipp_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned AngleBits = 16;
  localparam int unsigned PhaseBits = 32;
  localparam int unsigned PowerBits = 32;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicPerStage = 2;
  localparam int unsigned CordicGroups = CordicSteps / CordicPerStage;
  localparam int unsigned StepIdxBits = $clog2(CordicSteps);
  localparam int unsigned CordicBits = 34;
  localparam int unsigned ZBits = 33;
  localparam logic signed [CordicBits-1:0] CordicGain = 34'sd652032874;

  localparam int unsigned TrigBits = 16;
  localparam logic signed [TrigBits-1:0] TrigMax = 16'sd32767;
  localparam logic signed [TrigBits-1:0] TrigMin = -16'sd32767;

  localparam int unsigned ConstBits = 16;
  localparam logic signed [ConstBits-1:0] HalfQ15 = 16'sd16384;
  localparam logic signed [ConstBits-1:0] Root3HalfQ15 = 16'sd28378;
  localparam logic signed [ConstBits-1:0] ScaleQ15 = 16'sd26755;

  localparam int unsigned CoefBits = 18;
  localparam int unsigned ProdBits = CoefBits + SampleBits;
  localparam int unsigned AccBits = ProdBits + 1;
  localparam int unsigned ScaledBits = AccBits + ConstBits;
  localparam int unsigned NumPhase = 6;

  localparam logic signed [ZBits-1:0] AtanTurns [CordicSteps] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
    33'sd2670163, 33'sd1335086, 33'sd667544, 33'sd333772,
    33'sd166886, 33'sd83443, 33'sd41721, 33'sd20860
  };

  typedef enum logic [1:0] {
    Quad0   = 2'd0,
    Quad90  = 2'd1,
    Quad180 = 2'd2,
    Quad270 = 2'd3
  } ipp_quad_e;

  typedef struct packed {
    logic [SampleBits-1:0] id;
    logic [SampleBits-1:0] iq;
    logic [SampleBits-1:0] vd;
    logic [SampleBits-1:0] vq;
    logic [SampleBits-1:0] ed;
    logic [SampleBits-1:0] eq;
  } ipp_samp_t;

  typedef struct packed {
    logic [TrigBits-1:0] cos_v;
    logic [TrigBits-1:0] sin_v;
    ipp_samp_t           samp;
  } ipp_trig_t;

  typedef struct packed {
    logic [2:0][CoefBits-1:0]   kd;
    logic [2:0][CoefBits-1:0]   kq;
    logic [1:0][SampleBits-1:0] d;
    logic [1:0][SampleBits-1:0] q;
    logic [PowerBits-1:0]       act;
    logic [PowerBits-1:0]       react;
  } ipp_mid_t;

  typedef struct packed {
    logic [NumPhase-1:0][SampleBits-1:0] phase;
    logic [PowerBits-1:0]                act;
    logic [PowerBits-1:0]                react;
  } ipp_res_t;

endpackage

// ===== rtl/ipp_if.sv =====
`timescale 1ns / 1ps

interface ipp_in_if;
  import ipp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] current_d;
  logic [SampleBits-1:0] current_q;
  logic [SampleBits-1:0] volt_d;
  logic [SampleBits-1:0] volt_q;
  logic [SampleBits-1:0] grid_d;
  logic [SampleBits-1:0] grid_q;
  logic [AngleBits-1:0]  angle;

  modport source (
    output valid, current_d, current_q, volt_d, volt_q, grid_d, grid_q, angle,
    input  ready
  );
  modport sink (
    input  valid, current_d, current_q, volt_d, volt_q, grid_d, grid_q, angle,
    output ready
  );
endinterface

interface ipp_out_if;
  import ipp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] phase_a_current;
  logic [SampleBits-1:0] phase_b_current;
  logic [SampleBits-1:0] phase_c_current;
  logic [SampleBits-1:0] phase_a_volt;
  logic [SampleBits-1:0] phase_b_volt;
  logic [SampleBits-1:0] phase_c_volt;
  logic [PowerBits-1:0]  active_power;
  logic [PowerBits-1:0]  reactive_power;

  modport source (
    output valid, phase_a_current, phase_b_current, phase_c_current,
           phase_a_volt, phase_b_volt, phase_c_volt, active_power, reactive_power,
    input  ready
  );
  modport sink (
    input  valid, phase_a_current, phase_b_current, phase_c_current,
           phase_a_volt, phase_b_volt, phase_c_volt, active_power, reactive_power,
    output ready
  );
endinterface

// ===== rtl/ipp_cordic.sv =====
`timescale 1ns / 1ps

module ipp_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [ipp_pkg::AngleBits-1:0] angle_i,
  input  ipp_pkg::ipp_samp_t            samp_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output ipp_pkg::ipp_trig_t            trig_o
);
  import ipp_pkg::*;

  localparam int unsigned NumStages = CordicGroups + 2;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_in;
  logic [NumStages-1:0] en;
  logic [NumStages:0]   rdy;

  logic signed [CordicBits-1:0] x_q [0:CordicGroups];
  logic signed [CordicBits-1:0] y_q [0:CordicGroups];
  logic signed [ZBits-1:0]      z_q [0:CordicGroups];
  logic signed [CordicBits-1:0] x_d [1:CordicGroups];
  logic signed [CordicBits-1:0] y_d [1:CordicGroups];
  logic signed [ZBits-1:0]      z_d [1:CordicGroups];
  ipp_quad_e                    quad_q [0:CordicGroups];
  ipp_samp_t                    samp_q [0:CordicGroups];

  logic [PhaseBits-1:0] phase;
  logic [PhaseBits-1:0] phase_ofs;
  logic [PhaseBits-1:0] resid;
  ipp_quad_e            quad_init;
  logic signed [ZBits-1:0] z_init;

  logic signed [CordicBits-1:0] x_rnd;
  logic signed [CordicBits-1:0] y_rnd;
  logic signed [TrigBits-1:0]   c_sat;
  logic signed [TrigBits-1:0]   s_sat;
  logic signed [TrigBits-1:0]   cos_d;
  logic signed [TrigBits-1:0]   sin_d;
  ipp_trig_t                    trig_q;

  function automatic logic signed [TrigBits-1:0] sat_trig(logic signed [CordicBits-1:0] v);
    logic signed [TrigBits-1:0] r;
    if (v > CordicBits'(TrigMax)) begin
      r = TrigMax;
    end else if (v < CordicBits'(TrigMin)) begin
      r = TrigMin;
    end else begin
      r = TrigBits'(v);
    end
    return r;
  endfunction

  always_comb begin
    rdy[NumStages] = ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k]  = !v_q[k] || rdy[k+1];
      rdy[k] = en[k];
    end
    v_in[0] = valid_i;
    for (int k = 1; k < NumStages; k++) begin
      v_in[k] = v_q[k-1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // The angle is placed on a 32-bit turn and split into a quadrant and a residue.
  always_comb begin
    phase     = {angle_i, {(PhaseBits - AngleBits){1'b0}}};
    phase_ofs = phase + {2'b00, 1'b1, {(PhaseBits - 3){1'b0}}};
    quad_init = ipp_quad_e'(phase_ofs[PhaseBits-1 -: 2]);
    resid     = phase - {phase_ofs[PhaseBits-1 -: 2], {(PhaseBits - 2){1'b0}}};
    z_init    = signed'({resid[PhaseBits-1], resid});
  end

  always_comb begin
    logic signed [CordicBits-1:0] xt;
    logic signed [CordicBits-1:0] yt;
    logic signed [ZBits-1:0]      zt;
    logic signed [CordicBits-1:0] xs;
    logic signed [CordicBits-1:0] ys;
    logic [StepIdxBits-1:0]       idx;
    for (int j = 1; j <= CordicGroups; j++) begin
      xt = x_q[j-1];
      yt = y_q[j-1];
      zt = z_q[j-1];
      for (int t = 0; t < CordicPerStage; t++) begin
        idx = StepIdxBits'((j - 1) * CordicPerStage + t);
        xs  = yt >>> idx;
        ys  = xt >>> idx;
        if (!zt[ZBits-1]) begin
          xt = xt - xs;
          yt = yt + ys;
          zt = zt - AtanTurns[idx];
        end else begin
          xt = xt + xs;
          yt = yt - ys;
          zt = zt + AtanTurns[idx];
        end
      end
      x_d[j] = xt;
      y_d[j] = yt;
      z_d[j] = zt;
    end
  end

  always_comb begin
    x_rnd = (x_q[CordicGroups] + CordicBits'(HalfQ15)) >>> 15;
    y_rnd = (y_q[CordicGroups] + CordicBits'(HalfQ15)) >>> 15;
    c_sat = sat_trig(x_rnd);
    s_sat = sat_trig(y_rnd);
    case (quad_q[CordicGroups])
      Quad0: begin
        cos_d = c_sat;
        sin_d = s_sat;
      end
      Quad90: begin
        cos_d = -s_sat;
        sin_d = c_sat;
      end
      Quad180: begin
        cos_d = -c_sat;
        sin_d = -s_sat;
      end
      default: begin
        cos_d = s_sat;
        sin_d = -c_sat;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[0]    <= CordicGain;
      y_q[0]    <= '0;
      z_q[0]    <= z_init;
      quad_q[0] <= quad_init;
      samp_q[0] <= samp_i;
    end
    for (int j = 1; j <= CordicGroups; j++) begin
      if (en[j]) begin
        x_q[j]    <= x_d[j];
        y_q[j]    <= y_d[j];
        z_q[j]    <= z_d[j];
        quad_q[j] <= quad_q[j-1];
        samp_q[j] <= samp_q[j-1];
      end
    end
    if (en[NumStages-1]) begin
      trig_q.cos_v <= cos_d;
      trig_q.sin_v <= sin_d;
      trig_q.samp  <= samp_q[CordicGroups];
    end
  end

  assign trig_o = trig_q;

endmodule

// ===== rtl/ipp_coef.sv =====
`timescale 1ns / 1ps

module ipp_coef (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  ipp_pkg::ipp_trig_t trig_i,
  output logic               valid_o,
  input  logic               ready_i,
  output ipp_pkg::ipp_mid_t  mid_o
);
  import ipp_pkg::*;

  localparam int unsigned NumStages = 2;
  localparam int unsigned CProdBits = TrigBits + ConstBits;
  localparam int unsigned CSumBits = CProdBits + 2;
  localparam int unsigned PProdBits = 2 * SampleBits;
  localparam int unsigned PSumBits = PProdBits + 1;
  localparam logic signed [PSumBits-1:0] PowHi = PSumBits'({1'b0, {(PowerBits-1){1'b1}}});
  localparam logic signed [PSumBits-1:0] PowLo = -PowHi - PSumBits'(1);

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_in;
  logic [NumStages-1:0] en;
  logic [NumStages:0]   rdy;

  logic signed [TrigBits-1:0]  c_q;
  logic signed [TrigBits-1:0]  s_q;
  logic signed [CProdBits-1:0] pcr_q;
  logic signed [CProdBits-1:0] psr_q;
  logic signed [PProdBits-1:0] pa1_q;
  logic signed [PProdBits-1:0] pa2_q;
  logic signed [PProdBits-1:0] pr1_q;
  logic signed [PProdBits-1:0] pr2_q;
  ipp_samp_t                   samp_q;

  logic signed [CSumBits-1:0] c_sh;
  logic signed [CSumBits-1:0] s_sh;
  logic signed [CSumBits-1:0] sum_kdb;
  logic signed [CSumBits-1:0] sum_kqb;
  logic signed [CSumBits-1:0] sum_kdc;
  logic signed [CSumBits-1:0] sum_kqc;
  logic signed [PSumBits-1:0] act_sum;
  logic signed [PSumBits-1:0] react_sum;
  ipp_mid_t                   mid_d;
  ipp_mid_t                   mid_q;

  function automatic logic [PowerBits-1:0] sat_power(logic signed [PSumBits-1:0] v);
    logic signed [PSumBits-1:0] r;
    if (v > PowHi) begin
      r = PowHi;
    end else if (v < PowLo) begin
      r = PowLo;
    end else begin
      r = v;
    end
    return r[PowerBits-1:0];
  endfunction

  always_comb begin
    rdy[NumStages] = ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k]  = !v_q[k] || rdy[k+1];
      rdy[k] = en[k];
    end
    v_in[0] = valid_i;
    for (int k = 1; k < NumStages; k++) begin
      v_in[k] = v_q[k-1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      c_q    <= signed'(trig_i.cos_v);
      s_q    <= signed'(trig_i.sin_v);
      pcr_q  <= signed'(trig_i.cos_v) * Root3HalfQ15;
      psr_q  <= signed'(trig_i.sin_v) * Root3HalfQ15;
      pa1_q  <= signed'(trig_i.samp.ed) * signed'(trig_i.samp.id);
      pa2_q  <= signed'(trig_i.samp.eq) * signed'(trig_i.samp.iq);
      pr1_q  <= signed'(trig_i.samp.eq) * signed'(trig_i.samp.id);
      pr2_q  <= signed'(trig_i.samp.ed) * signed'(trig_i.samp.iq);
      samp_q <= trig_i.samp;
    end
    if (en[1]) begin
      mid_q <= mid_d;
    end
  end

  // Phase b and c coefficients are rounded from Q30 to Q15; phase a is exact.
  always_comb begin
    c_sh      = CSumBits'(c_q) * CSumBits'(HalfQ15);
    s_sh      = CSumBits'(s_q) * CSumBits'(HalfQ15);
    sum_kdb   = -c_sh + CSumBits'(psr_q) + CSumBits'(HalfQ15);
    sum_kqb   = s_sh + CSumBits'(pcr_q) + CSumBits'(HalfQ15);
    sum_kdc   = -c_sh - CSumBits'(psr_q) + CSumBits'(HalfQ15);
    sum_kqc   = s_sh - CSumBits'(pcr_q) + CSumBits'(HalfQ15);
    act_sum   = PSumBits'(pa1_q) + PSumBits'(pa2_q);
    react_sum = PSumBits'(pr1_q) - PSumBits'(pr2_q);

    mid_d.kd[0] = CoefBits'(c_q);
    mid_d.kq[0] = -CoefBits'(s_q);
    mid_d.kd[1] = CoefBits'(sum_kdb >>> 15);
    mid_d.kq[1] = CoefBits'(sum_kqb >>> 15);
    mid_d.kd[2] = CoefBits'(sum_kdc >>> 15);
    mid_d.kq[2] = CoefBits'(sum_kqc >>> 15);
    mid_d.d[0]  = samp_q.id;
    mid_d.q[0]  = samp_q.iq;
    mid_d.d[1]  = samp_q.vd;
    mid_d.q[1]  = samp_q.vq;
    mid_d.act   = sat_power(act_sum);
    mid_d.react = sat_power(react_sum);
  end

  assign mid_o = mid_q;

endmodule

// ===== rtl/ipp_phase.sv =====
`timescale 1ns / 1ps

module ipp_phase (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  ipp_pkg::ipp_mid_t mid_i,
  output logic              valid_o,
  input  logic              ready_i,
  output ipp_pkg::ipp_res_t res_o
);
  import ipp_pkg::*;

  localparam int unsigned NumStages = 4;
  localparam int unsigned RndBits = ScaledBits + 1;
  localparam logic signed [RndBits-1:0] SampHi = RndBits'({1'b0, {(SampleBits-1){1'b1}}});
  localparam logic signed [RndBits-1:0] SampLo = -SampHi - RndBits'(1);
  localparam logic signed [RndBits-1:0] RndHalf = RndBits'(1) <<< 29;

  logic [NumStages-1:0] v_q;
  logic [NumStages-1:0] v_in;
  logic [NumStages-1:0] en;
  logic [NumStages:0]   rdy;

  logic signed [ProdBits-1:0]   pd_q [NumPhase];
  logic signed [ProdBits-1:0]   pq_q [NumPhase];
  logic signed [AccBits-1:0]    acc_q [NumPhase];
  logic signed [ScaledBits-1:0] sc_q [NumPhase];
  logic [PowerBits-1:0]         act_q [NumStages-1];
  logic [PowerBits-1:0]         react_q [NumStages-1];
  ipp_res_t                     res_q;

  function automatic logic [SampleBits-1:0] sat_sample(logic signed [ScaledBits-1:0] v);
    logic signed [RndBits-1:0] t;
    logic signed [RndBits-1:0] r;
    t = (RndBits'(v) + RndHalf) >>> 30;
    if (t > SampHi) begin
      r = SampHi;
    end else if (t < SampLo) begin
      r = SampLo;
    end else begin
      r = t;
    end
    return r[SampleBits-1:0];
  endfunction

  always_comb begin
    rdy[NumStages] = ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k]  = !v_q[k] || rdy[k+1];
      rdy[k] = en[k];
    end
    v_in[0] = valid_i;
    for (int k = 1; k < NumStages; k++) begin
      v_in[k] = v_q[k-1];
    end
  end

  assign ready_o = rdy[0];
  assign valid_o = v_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // Outputs zero to two are the currents, three to five the voltages.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int n = 0; n < NumPhase; n++) begin
        pd_q[n] <= signed'(mid_i.kd[n % 3]) * signed'(mid_i.d[n / 3]);
        pq_q[n] <= signed'(mid_i.kq[n % 3]) * signed'(mid_i.q[n / 3]);
      end
      act_q[0]   <= mid_i.act;
      react_q[0] <= mid_i.react;
    end
    if (en[1]) begin
      for (int n = 0; n < NumPhase; n++) begin
        acc_q[n] <= AccBits'(pd_q[n]) + AccBits'(pq_q[n]);
      end
      act_q[1]   <= act_q[0];
      react_q[1] <= react_q[0];
    end
    if (en[2]) begin
      for (int n = 0; n < NumPhase; n++) begin
        sc_q[n] <= ScaledBits'(acc_q[n]) * ScaledBits'(ScaleQ15);
      end
      act_q[2]   <= act_q[1];
      react_q[2] <= react_q[1];
    end
    if (en[3]) begin
      for (int n = 0; n < NumPhase; n++) begin
        res_q.phase[n] <= sat_sample(sc_q[n]);
      end
      res_q.act   <= act_q[2];
      res_q.react <= react_q[2];
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/inverse_park_with_power.sv =====
`timescale 1ns / 1ps

// Power-invariant inverse Park transform with dq active and reactive power.
// The input channel carries one measurement set per transfer: dq current,
// dq converter voltage, dq grid voltage and a 16-bit angle (a full turn is
// 65536). The output channel carries the three rebuilt phase currents and
// voltages, saturated to 16 bits, and the active and reactive power,
// saturated to 32 bits. Both channels use a valid/ready handshake.
// The pipeline has ten stages for the CORDIC (an entry stage, stages of
// two rotations each and an output stage), two for the coefficient and
// power products, and four for the multiply, sum, scale and saturate of
// the phase values. One transfer per cycle is sustained while ready is
// high; every stage holds its own valid bit, so empty stages fill while
// the output stalls. When the receiver holds ready low, the last stage
// keeps its result and the stages behind it fill up before ready on the
// input drops. Reset clears all valid bits; no result is pending after reset.

module inverse_park_with_power (
  input  logic clk_i,
  input  logic rst_ni,
  ipp_in_if.sink    in_i,
  ipp_out_if.source out_o
);
  import ipp_pkg::*;

  ipp_samp_t samp;
  ipp_trig_t trig;
  ipp_mid_t  mid;
  ipp_res_t  res;
  logic      trig_valid;
  logic      trig_ready;
  logic      mid_valid;
  logic      mid_ready;

  assign samp.id = in_i.current_d;
  assign samp.iq = in_i.current_q;
  assign samp.vd = in_i.volt_d;
  assign samp.vq = in_i.volt_q;
  assign samp.ed = in_i.grid_d;
  assign samp.eq = in_i.grid_q;

  ipp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .angle_i (in_i.angle),
    .samp_i  (samp),
    .valid_o (trig_valid),
    .ready_i (trig_ready),
    .trig_o  (trig)
  );

  ipp_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (trig_valid),
    .ready_o (trig_ready),
    .trig_i  (trig),
    .valid_o (mid_valid),
    .ready_i (mid_ready),
    .mid_o   (mid)
  );

  ipp_phase u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mid_valid),
    .ready_o (mid_ready),
    .mid_i   (mid),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.phase_a_current = res.phase[0];
  assign out_o.phase_b_current = res.phase[1];
  assign out_o.phase_c_current = res.phase[2];
  assign out_o.phase_a_volt    = res.phase[3];
  assign out_o.phase_b_volt    = res.phase[4];
  assign out_o.phase_c_volt    = res.phase[5];
  assign out_o.active_power    = res.act;
  assign out_o.reactive_power  = res.react;

endmodule

// ===== dv/inverse_park_with_power_checker.sv =====
`timescale 1ns / 1ps

module inverse_park_with_power_checker (
  input  logic clk_i,
  input  logic rst_ni,
  ipp_in_if    in_i,
  ipp_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);
  import ipp_pkg::*;

  localparam longint GainQ30 = 652032874;
  localparam longint HalfK = 16384;
  localparam longint Root3HalfK = 28378;
  localparam longint RootTwoThirdsK = 26755;
  localparam longint ArcTurn [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
    41721, 20860
  };

  string phase_label [6] = '{
    "phase_a_current", "phase_b_current", "phase_c_current",
    "phase_a_volt", "phase_b_volt", "phase_c_volt"
  };

  ipp_res_t phase_power_q [$];
  int       mismatch_count;
  int       result_count;

  task automatic log_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [SampleBits-1:0] phase_sample(input longint kd30, input longint kq30,
                                                        input longint d, input longint q);
    longint kd;
    longint kq;
    longint acc;
    longint v;
    kd = (kd30 + 16384) >>> 15;
    kq = (kq30 + 16384) >>> 15;
    acc = kd * d + kq * q;
    v = (acc * RootTwoThirdsK + (64'sd1 <<< 29)) >>> 30;
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[SampleBits-1:0];
  endfunction

  function automatic logic [PowerBits-1:0] clip_power(input longint v);
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
    end
    return v[PowerBits-1:0];
  endfunction

  function automatic ipp_res_t inverse_park_set(input ipp_samp_t smp,
                                                input logic [AngleBits-1:0] ang);
    ipp_res_t   res;
    logic [31:0] turn;
    logic [31:0] rounded;
    logic [31:0] resid;
    ipp_quad_e  quad;
    longint     z;
    longint     x;
    longint     y;
    longint     xs;
    longint     ys;
    longint     c;
    longint     s;
    longint     co;
    longint     si;
    longint     d;
    longint     q;
    longint     id;
    longint     iq;
    longint     ed;
    longint     eq;
    turn = {ang, 16'h0000};
    rounded = turn + 32'h2000_0000;
    quad = ipp_quad_e'(rounded[31:30]);
    resid = turn - {quad, 30'b0};
    z = longint'($signed(resid));
    x = GainQ30;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (z >= 0) begin
        x = x - xs;
        y = y + ys;
        z = z - ArcTurn[i];
      end else begin
        x = x + xs;
        y = y - ys;
        z = z + ArcTurn[i];
      end
    end
    c = (x + 16384) >>> 15;
    s = (y + 16384) >>> 15;
    if (c > 32767) c = 32767;
    if (c < -32767) c = -32767;
    if (s > 32767) s = 32767;
    if (s < -32767) s = -32767;
    case (quad)
      Quad0: begin
        co = c;
        si = s;
      end
      Quad90: begin
        co = -s;
        si = c;
      end
      Quad180: begin
        co = -c;
        si = -s;
      end
      default: begin
        co = s;
        si = -c;
      end
    endcase
    for (int k = 0; k < 2; k++) begin
      d = longint'($signed(k == 0 ? smp.id : smp.vd));
      q = longint'($signed(k == 0 ? smp.iq : smp.vq));
      res.phase[3*k]   = phase_sample(co * 32768, -si * 32768, d, q);
      res.phase[3*k+1] = phase_sample(-co * HalfK + si * Root3HalfK,
                                      si * HalfK + co * Root3HalfK, d, q);
      res.phase[3*k+2] = phase_sample(-co * HalfK - si * Root3HalfK,
                                      si * HalfK - co * Root3HalfK, d, q);
    end
    id = longint'($signed(smp.id));
    iq = longint'($signed(smp.iq));
    ed = longint'($signed(smp.ed));
    eq = longint'($signed(smp.eq));
    res.act = clip_power(ed * id + eq * iq);
    res.react = clip_power(eq * id - ed * iq);
    return res;
  endfunction

  always @(posedge clk_i) begin
    ipp_samp_t smp;
    ipp_res_t  got;
    ipp_res_t  want;
    if (rst_ni) begin
      if (in_i.valid && in_i.ready) begin
        smp.id = in_i.current_d;
        smp.iq = in_i.current_q;
        smp.vd = in_i.volt_d;
        smp.vq = in_i.volt_q;
        smp.ed = in_i.grid_d;
        smp.eq = in_i.grid_q;
        phase_power_q.push_back(inverse_park_set(smp, in_i.angle));
      end
      if (out_i.valid && out_i.ready) begin
        got.phase[0] = out_i.phase_a_current;
        got.phase[1] = out_i.phase_b_current;
        got.phase[2] = out_i.phase_c_current;
        got.phase[3] = out_i.phase_a_volt;
        got.phase[4] = out_i.phase_b_volt;
        got.phase[5] = out_i.phase_c_volt;
        got.act = out_i.active_power;
        got.react = out_i.reactive_power;
        if (phase_power_q.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with nothing outstanding", result_count));
        end else begin
          want = phase_power_q.pop_front();
          for (int p = 0; p < 6; p++) begin
            if (got.phase[p] !== want.phase[p]) begin
              log_mismatch($sformatf("%s result %0d: got %0d want %0d", phase_label[p],
                                     result_count, $signed(got.phase[p]),
                                     $signed(want.phase[p])));
            end
          end
          if (got.act !== want.act) begin
            log_mismatch($sformatf("active_power result %0d: got %0d want %0d", result_count,
                                   $signed(got.act), $signed(want.act)));
          end
          if (got.react !== want.react) begin
            log_mismatch($sformatf("reactive_power result %0d: got %0d want %0d",
                                   result_count, $signed(got.react), $signed(want.react)));
          end
        end
        result_count++;
      end
    end
    fail_count_o <= mismatch_count;
    pending_o <= phase_power_q.size();
    checked_o <= result_count;
  end

endmodule

// ===== dv/inverse_park_with_power_tb.sv =====
`timescale 1ns / 1ps

module inverse_park_with_power_tb;
  import ipp_pkg::*;

  typedef struct packed {
    ipp_samp_t            samp;
    logic [AngleBits-1:0] angle;
  } meas_t;

  typedef enum logic [1:0] {
    RxOpen   = 2'd0,
    RxCoin   = 2'd1,
    RxEvery4 = 2'd2,
    RxSparse = 2'd3
  } rx_mode_e;

  localparam int RandomSets = 550;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 40;
  localparam int WatchdogLimit = 2000;

  logic clk_i;
  logic rst_ni;
  logic long_hold;
  int   fail_count;
  int   pending;
  int   checked;
  int   idle_cycles;
  int   directed_count;
  int   random_count;

  ipp_in_if  in_ch ();
  ipp_out_if out_ch ();

  inverse_park_with_power DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  inverse_park_with_power_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_i       (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic meas_t make_set(input logic [15:0] id, input logic [15:0] iq,
                                     input logic [15:0] vd, input logic [15:0] vq,
                                     input logic [15:0] ed, input logic [15:0] eq,
                                     input logic [15:0] ang);
    meas_t m;
    m.samp.id = id;
    m.samp.iq = iq;
    m.samp.vd = vd;
    m.samp.vq = vq;
    m.samp.ed = ed;
    m.samp.eq = eq;
    m.angle = ang;
    return m;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: v = 16'h8000;
      1: v = 16'h7FFF;
      2: v = 16'($urandom_range(0, 64));
      3: v = -16'($urandom_range(0, 64));
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [15:0] rand_angle();
    logic [15:0] a;
    if ($urandom_range(0, 4) == 0) begin
      a = {3'($urandom_range(0, 7)), 13'h0000} + 16'($urandom_range(0, 2)) - 16'd1;
    end else begin
      a = 16'($urandom);
    end
    return a;
  endfunction

  task automatic offer_set(input meas_t m);
    in_ch.valid <= 1'b1;
    in_ch.current_d <= m.samp.id;
    in_ch.current_q <= m.samp.iq;
    in_ch.volt_d <= m.samp.vd;
    in_ch.volt_q <= m.samp.vq;
    in_ch.grid_d <= m.samp.ed;
    in_ch.grid_q <= m.samp.eq;
    in_ch.angle <= m.angle;
    @(posedge clk_i);
    while (!in_ch.ready) begin
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending != 0);
  endtask

  // The receiver mixes open stretches, coin-flip stalls and fixed patterns, and
  // honors a request for one long stall that lets the pipeline back up.
  initial begin
    rx_mode_e mode;
    int       seg;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        long_hold = 1'b0;
      end
      mode = rx_mode_e'($urandom_range(0, 3));
      seg = $urandom_range(4, 60);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          RxOpen:   out_ch.ready <= 1'b1;
          RxCoin:   out_ch.ready <= 1'($urandom_range(0, 1));
          RxEvery4: out_ch.ready <= (k % 4 != 3);
          default:  out_ch.ready <= (k % 5 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WatchdogLimit) begin
        $display("Watchdog: no transfer for %0d cycles", WatchdogLimit);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    meas_t directed [$];
    int    burst;
    rst_ni = 1'b0;
    long_hold = 1'b0;
    idle_cycles = 0;
    directed_count = 0;
    random_count = 0;
    in_ch.valid = 1'b0;
    in_ch.current_d = '0;
    in_ch.current_q = '0;
    in_ch.volt_d = '0;
    in_ch.volt_q = '0;
    in_ch.grid_d = '0;
    in_ch.grid_q = '0;
    in_ch.angle = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Quadrant centers and boundaries, full-scale samples, and sets that drive
    // the phase values and the active power into saturation.
    directed.push_back(make_set(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                16'h0000));
    directed.push_back(make_set(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h0000));
    directed.push_back(make_set(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h4000));
    directed.push_back(make_set(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'h8000));
    directed.push_back(make_set(16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'hC000));
    directed.push_back(make_set(16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h1234, 16'hEDCC,
                                16'h1FFF));
    directed.push_back(make_set(16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h1234, 16'hEDCC,
                                16'h2000));
    directed.push_back(make_set(16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h1234, 16'hEDCC,
                                16'h6000));
    directed.push_back(make_set(16'h4000, 16'hC000, 16'h2000, 16'hE000, 16'h1234, 16'hEDCC,
                                16'hA000));
    directed.push_back(make_set(16'h0001, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF,
                                16'hFFFF));
    directed.push_back(make_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'hE000));
    directed.push_back(make_set(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                16'hE000));
    directed.push_back(make_set(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                16'h6000));
    directed.push_back(make_set(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000,
                                16'hA000));
    directed.push_back(make_set(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                                16'h2000));
    directed.push_back(make_set(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA,
                                16'h5555));
    directed.push_back(make_set(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555,
                                16'hAAAA));
    directed.push_back(make_set(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                                16'h0001));
    foreach (directed[i]) begin
      offer_set(directed[i]);
      directed_count++;
    end
    drain_results();

    while (random_count < RandomSets) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
      for (int j = 0; j < burst && random_count < RandomSets; j++) begin
        if (random_count == 200) begin
          long_hold = 1'b1;
        end
        if (random_count == 400) begin
          drain_results();
        end
        offer_set(make_set(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                           rand_sample(), rand_sample(), rand_angle()));
        random_count++;
      end
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    $display("Covered %0d directed and %0d random measurement sets; %0d results checked.",
             directed_count, random_count, checked);
    $display("Included quadrant boundaries, saturating phases and power, and a long stall.");
    if (pending != 0) begin
      $display("%0d expected results never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ipp_pkg.sv
rtl/ipp_if.sv
rtl/ipp_cordic.sv
rtl/ipp_coef.sv
rtl/ipp_phase.sv
rtl/inverse_park_with_power.sv
dv/inverse_park_with_power_checker.sv
dv/inverse_park_with_power_tb.sv
